/* rtl/core/jos_pkg.sv */
// Shared types, constants and helper functions for the job order scheduler.
package jos_pkg;

  // Table depth and derived slot index width.
  localparam int MAX_JOBS = 16;
  localparam int SLOT_W   = $clog2(MAX_JOBS);
  localparam int CNT_W    = SLOT_W + 1;

  // Field widths of a job request.
  localparam int ID_W    = 5;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int OPER_W  = 32;
  localparam int MODE_W  = 2;
  localparam int KEY_W   = BURST_W;

  // Scheduling mode codes; the unused code behaves as first come first served.
  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

  // One stored job record (the job number is implied by the slot).
  typedef struct packed {
    logic [BURST_W-1:0]       burst;
    logic [PRIO_W-1:0]        prio;
    logic [FUNC_W-1:0]        func;
    logic signed [OPER_W-1:0] operand_a;
    logic signed [OPER_W-1:0] operand_b;
  } rec_t;

  // Access request from the sequencer to the record store.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    rec_t              wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } store_req_t;

  // Ordering key of a record. In first come first served mode every key is
  // equal, so the ascending scan picks the lowest pending slot.
  function automatic logic [KEY_W-1:0] sort_key(input logic [MODE_W-1:0] mode,
                                                input rec_t rec);
    logic [KEY_W-1:0] key;
    begin
      case (mode)
        MODE_SJF:  key = rec.burst;
        MODE_PRIO: key = KEY_W'(rec.prio);
        default:   key = '0;
      endcase
      return key;
    end
  endfunction

endpackage

/* rtl/core/jos_if.sv */
// Valid/ready channel interfaces for job requests, results and configuration.
interface jos_in_if;
  logic                              valid;
  logic                              ready;
  logic [jos_pkg::ID_W-1:0]          job_id;
  logic [jos_pkg::BURST_W-1:0]       burst_time;
  logic [jos_pkg::PRIO_W-1:0]        priority_level;
  logic [jos_pkg::FUNC_W-1:0]        func_code;
  logic signed [jos_pkg::OPER_W-1:0] operand_a;
  logic signed [jos_pkg::OPER_W-1:0] operand_b;
  logic                              last_job;

  modport source (output valid, job_id, burst_time, priority_level, func_code,
                  operand_a, operand_b, last_job, input ready);
  modport sink (input valid, job_id, burst_time, priority_level, func_code,
                operand_a, operand_b, last_job, output ready);
endinterface

interface jos_out_if;
  logic                              valid;
  logic                              ready;
  logic [jos_pkg::ID_W-1:0]          out_job_id;
  logic [jos_pkg::BURST_W-1:0]       out_burst;
  logic [jos_pkg::PRIO_W-1:0]        out_priority;
  logic [jos_pkg::FUNC_W-1:0]        out_func;
  logic signed [jos_pkg::OPER_W-1:0] out_operand_a;
  logic signed [jos_pkg::OPER_W-1:0] out_operand_b;
  logic                              out_last;

  modport source (output valid, out_job_id, out_burst, out_priority, out_func,
                  out_operand_a, out_operand_b, out_last, input ready);
  modport sink (input valid, out_job_id, out_burst, out_priority, out_func,
                out_operand_a, out_operand_b, out_last, output ready);
endinterface

interface jos_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [jos_pkg::MODE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/core/jos_store.sv */
// Record store: one write port and one read port with registered read data.
module jos_store (
  input  logic                clk,
  input  jos_pkg::store_req_t req,
  output jos_pkg::rec_t       rd_data
);

  jos_pkg::rec_t mem [jos_pkg::MAX_JOBS];
  jos_pkg::rec_t rd_data_r;

  // Synchronous write and read; the read data is registered and appears in the cycle after the request.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/jos_seq.sv */
// Sequencer: loads job requests into the store and emits them in scheduled order.
module jos_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [jos_pkg::MODE_W-1:0]  mode,
  jos_in_if.sink                      in_chan,
  jos_out_if.source                   out_chan,
  output jos_pkg::store_req_t         store_req,
  input  jos_pkg::rec_t               rd_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [jos_pkg::MAX_JOBS-1:0] valid_r, valid_nxt;
  logic [jos_pkg::MAX_JOBS-1:0] done_r, done_nxt;
  logic [jos_pkg::CNT_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                         rd_pend_r, rd_pend_nxt;
  logic [jos_pkg::SLOT_W-1:0]   rd_slot_r, rd_slot_nxt;
  logic                         best_found_r, best_found_nxt;
  logic [jos_pkg::SLOT_W-1:0]   best_slot_r, best_slot_nxt;
  logic [jos_pkg::KEY_W-1:0]    best_key_r, best_key_nxt;
  jos_pkg::rec_t                best_rec_r, best_rec_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [jos_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  jos_pkg::rec_t                out_rec_r, out_rec_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         in_fire;
  logic                         id_in_range;
  logic [jos_pkg::SLOT_W-1:0]   in_slot;
  logic [jos_pkg::MAX_JOBS-1:0] in_bit;
  logic [jos_pkg::MAX_JOBS-1:0] best_bit;
  logic [jos_pkg::KEY_W-1:0]    rd_key;
  logic                         rd_pending;
  jos_pkg::rec_t                in_rec;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Slot decode of the incoming job number.
  assign id_in_range = (in_chan.job_id != '0) &&
                       (32'(in_chan.job_id) <= jos_pkg::MAX_JOBS);
  assign in_slot     = jos_pkg::SLOT_W'(in_chan.job_id - jos_pkg::ID_W'(1));

  always_comb begin
    in_rec.burst     = in_chan.burst_time;
    in_rec.prio      = in_chan.priority_level;
    in_rec.func      = in_chan.func_code;
    in_rec.operand_a = in_chan.operand_a;
    in_rec.operand_b = in_chan.operand_b;
  end

  // One-hot masks of the incoming slot and the current winner.
  always_comb begin
    for (int i = 0; i < jos_pkg::MAX_JOBS; i++) begin
      in_bit[i]   = id_in_range && (in_slot == jos_pkg::SLOT_W'(i));
      best_bit[i] = (best_slot_r == jos_pkg::SLOT_W'(i));
    end
  end

  // Key and eligibility of the entry returned by the store this cycle.
  assign rd_key     = jos_pkg::sort_key(mode, rd_data);
  assign rd_pending = valid_r[rd_slot_r] && !done_r[rd_slot_r];

  // Store access, state transitions and the min search.
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    done_nxt       = done_r;
    scan_cnt_nxt   = scan_cnt_r;
    rd_pend_nxt    = 1'b0;
    rd_slot_nxt    = rd_slot_r;
    best_found_nxt = best_found_r;
    best_slot_nxt  = best_slot_r;
    best_key_nxt   = best_key_r;
    best_rec_nxt   = best_rec_r;
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_rec_nxt    = out_rec_r;
    out_last_nxt   = out_last_r;

    store_req.we    = 1'b0;
    store_req.waddr = in_slot;
    store_req.wdata = in_rec;
    store_req.re    = 1'b0;
    store_req.raddr = scan_cnt_r[jos_pkg::SLOT_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          store_req.we = id_in_range;
          valid_nxt    = valid_r | in_bit;
          if (in_chan.last_job && ((valid_r | in_bit) != '0)) begin
            state_nxt      = ST_SCAN;
            done_nxt       = '0;
            scan_cnt_nxt   = '0;
            best_found_nxt = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        // Issue reads across the table in ascending slot order.
        if (scan_cnt_r != jos_pkg::CNT_W'(jos_pkg::MAX_JOBS)) begin
          store_req.re = 1'b1;
          rd_pend_nxt  = 1'b1;
          rd_slot_nxt  = scan_cnt_r[jos_pkg::SLOT_W-1:0];
          scan_cnt_nxt = scan_cnt_r + jos_pkg::CNT_W'(1);
        end
        // Strict compare keeps the lowest slot among equal keys.
        if (rd_pend_r && rd_pending && (!best_found_r || (rd_key < best_key_r))) begin
          best_found_nxt = 1'b1;
          best_slot_nxt  = rd_slot_r;
          best_key_nxt   = rd_key;
          best_rec_nxt   = rd_data;
        end
        // Scan finished: hand the winner to the output register.
        if ((scan_cnt_r == jos_pkg::CNT_W'(jos_pkg::MAX_JOBS)) && !rd_pend_r) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = best_slot_r;
          out_rec_nxt   = best_rec_r;
          out_last_nxt  = ((valid_r & ~done_r & ~best_bit) == '0);
          done_nxt      = done_r | best_bit;
          state_nxt     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            valid_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            scan_cnt_nxt   = '0;
            best_found_nxt = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      done_r       <= '0;
      scan_cnt_r   <= '0;
      rd_pend_r    <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      done_r       <= done_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      rd_pend_r    <= rd_pend_nxt;
      best_found_r <= best_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_slot_r   <= rd_slot_nxt;
    best_slot_r <= best_slot_nxt;
    best_key_r  <= best_key_nxt;
    best_rec_r  <= best_rec_nxt;
    out_slot_r  <= out_slot_nxt;
    out_rec_r   <= out_rec_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Result channel.
  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_job_id    = jos_pkg::ID_W'(32'(out_slot_r) + 1);
  assign out_chan.out_burst     = out_rec_r.burst;
  assign out_chan.out_priority  = out_rec_r.prio;
  assign out_chan.out_func      = out_rec_r.func;
  assign out_chan.out_operand_a = out_rec_r.operand_a;
  assign out_chan.out_operand_b = out_rec_r.operand_b;
  assign out_chan.out_last      = out_last_r;

endmodule

/* rtl/core/job_order_scheduler_unit.sv */
// Top level of the job order scheduler: mode register, sequencer and record store.
//
// Job requests arrive on in_chan, one per cycle while the block is loading.
// Each request is stored in the slot named by its job number (1..16); a
// repeated number overwrites, and a number outside that range stores nothing.
// A request with last_job set starts the ordered run: every loaded job is
// sent on out_chan, ordered by job number, by burst time or by priority as
// cfg_chan selects, with equal keys in job-number order. out_last marks the
// final result, after which the table is empty and loading resumes.
// Each result comes from a full scan of the record store, one entry read per
// cycle, and in_chan is not ready during the run. A stalled receiver holds
// the result in the output register and the scan waits. A last request
// with an empty table gives no result. Reset clears the loaded table and
// sets the mode to first come first served; the store contents need no
// clearing. cfg_chan is always ready; the user must write it only while
// the block is idle, which the block itself does not enforce.
module job_order_scheduler_unit (
  input logic        clk,
  input logic        rst_n,
  jos_in_if.sink     in_chan,
  jos_out_if.source  out_chan,
  jos_cfg_if.sink    cfg_chan
);

  logic [jos_pkg::MODE_W-1:0] mode_r;
  jos_pkg::store_req_t        store_req;
  jos_pkg::rec_t              rd_data;

  // Scheduling mode register.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jos_pkg::MODE_FCFS;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      mode_r <= cfg_chan.data;
    end
  end

  jos_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .store_req (store_req),
    .rd_data   (rd_data)
  );

  jos_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

endmodule

/* bench/tb.sv */
// Testbench for the job order scheduler: job batches in every mode, checked by a scoreboard.
`timescale 1ns / 1ps

module tb;

  // Function codes carried with each job, and the unused mode code.
  localparam logic [jos_pkg::FUNC_W-1:0] FUNC_SUM     = 2'd0;
  localparam logic [jos_pkg::FUNC_W-1:0] FUNC_PRODUCT = 2'd1;
  localparam logic [jos_pkg::FUNC_W-1:0] FUNC_POWER   = 2'd2;
  localparam logic [jos_pkg::FUNC_W-1:0] FUNC_FIB     = 2'd3;
  localparam logic [jos_pkg::MODE_W-1:0] MODE_UNUSED  = 2'd3;

  // Cycles to let pass after the last result: two full table scans.
  localparam int RUN_GAP = 2 * (jos_pkg::MAX_JOBS + 2) + 4;
  localparam int ID_MAX  = (1 << jos_pkg::ID_W) - 1;

  // One job request as it is sent.
  typedef struct {
    logic [jos_pkg::ID_W-1:0]          id;
    logic [jos_pkg::BURST_W-1:0]       burst;
    logic [jos_pkg::PRIO_W-1:0]        prio;
    logic [jos_pkg::FUNC_W-1:0]        func;
    logic signed [jos_pkg::OPER_W-1:0] opa;
    logic signed [jos_pkg::OPER_W-1:0] opb;
    logic                              last;
  } job_req_t;

  // One ordered job as it should come out.
  typedef struct {
    logic [jos_pkg::ID_W-1:0]          job_id;
    logic [jos_pkg::BURST_W-1:0]       burst;
    logic [jos_pkg::PRIO_W-1:0]        prio;
    logic [jos_pkg::FUNC_W-1:0]        func;
    logic signed [jos_pkg::OPER_W-1:0] opa;
    logic signed [jos_pkg::OPER_W-1:0] opb;
    logic                              last;
  } job_result_t;

  logic clk = 1'b0;
  logic rst_n;

  jos_in_if  in_chan ();
  jos_out_if out_chan ();
  jos_cfg_if cfg_chan ();

  job_order_scheduler_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Scoreboard state: the job table as the block should hold it.
  jos_pkg::rec_t              job_table [jos_pkg::MAX_JOBS];
  bit                         job_loaded [jos_pkg::MAX_JOBS];
  logic [jos_pkg::MODE_W-1:0] sched_mode = jos_pkg::MODE_FCFS;
  job_result_t                pending_results [$];

  int  mismatch_count  = 0;
  int  jobs_sent       = 0;
  int  results_checked = 0;
  int  runs_started    = 0;
  bit  [3:0] modes_used = 4'b0001;
  bit  in_idle  = 1'b1;
  bit  out_idle = 1'b1;

  // Clock generation.
  always #10 clk = ~clk;

  // Print one line for each of the first 100 mismatches and count them all.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Ordering key of a loaded slot in the current mode.
  function automatic int order_key(input int slot);
    case (sched_mode)
      jos_pkg::MODE_SJF:  return int'(job_table[slot].burst);
      jos_pkg::MODE_PRIO: return int'(job_table[slot].prio);
      default:            return slot;
    endcase
  endfunction

  // Store one accepted request; on a last request, queue the ordered run.
  function automatic void predict_job(input job_req_t j);
    int          order [jos_pkg::MAX_JOBS];
    int          count;
    int          cur;
    int          k;
    int          i;
    job_result_t r;
    if (j.id >= 1 && j.id <= jos_pkg::MAX_JOBS) begin
      job_loaded[j.id - 1] = 1'b1;
      job_table[j.id - 1].burst = j.burst;
      job_table[j.id - 1].prio = j.prio;
      job_table[j.id - 1].func = j.func;
      job_table[j.id - 1].operand_a = j.opa;
      job_table[j.id - 1].operand_b = j.opb;
    end
    if (!j.last) return;
    count = 0;
    for (i = 0; i < jos_pkg::MAX_JOBS; i++) begin
      if (job_loaded[i]) begin
        order[count] = i;
        count++;
      end
    end
    // Stable insertion sort keeps equal keys in job-number order.
    for (i = 1; i < count; i++) begin
      cur = order[i];
      k = i;
      while (k > 0 && order_key(order[k - 1]) > order_key(cur)) begin
        order[k] = order[k - 1];
        k--;
      end
      order[k] = cur;
    end
    for (i = 0; i < count; i++) begin
      r.job_id = jos_pkg::ID_W'(order[i] + 1);
      r.burst = job_table[order[i]].burst;
      r.prio = job_table[order[i]].prio;
      r.func = job_table[order[i]].func;
      r.opa = job_table[order[i]].operand_a;
      r.opb = job_table[order[i]].operand_b;
      r.last = (i == count - 1);
      pending_results.push_back(r);
    end
    for (i = 0; i < jos_pkg::MAX_JOBS; i++) job_loaded[i] = 1'b0;
    runs_started++;
  endfunction

  function automatic job_req_t make_job(input logic [jos_pkg::ID_W-1:0] id,
                                        input logic [jos_pkg::BURST_W-1:0] burst,
                                        input logic [jos_pkg::PRIO_W-1:0] prio,
                                        input logic [jos_pkg::FUNC_W-1:0] func,
                                        input logic signed [jos_pkg::OPER_W-1:0] opa,
                                        input logic signed [jos_pkg::OPER_W-1:0] opb,
                                        input logic last);
    job_req_t j;
    j.id = id;
    j.burst = burst;
    j.prio = prio;
    j.func = func;
    j.opa = opa;
    j.opb = opb;
    j.last = last;
    return j;
  endfunction

  // Operands lean toward the signed extremes now and then.
  function automatic logic signed [jos_pkg::OPER_W-1:0] random_operand();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // A random in-range job; narrow keys make ties common.
  function automatic job_req_t random_job(input bit narrow);
    job_req_t j;
    j.id = jos_pkg::ID_W'($urandom_range(1, jos_pkg::MAX_JOBS));
    j.burst = narrow ? jos_pkg::BURST_W'($urandom_range(0, 3))
                     : jos_pkg::BURST_W'($urandom());
    j.prio = narrow ? jos_pkg::PRIO_W'($urandom_range(0, 3))
                    : jos_pkg::PRIO_W'($urandom());
    j.func = jos_pkg::FUNC_W'($urandom_range(0, 3));
    j.opa = random_operand();
    j.opb = random_operand();
    j.last = 1'b0;
    return j;
  endfunction

  // Send one request, after a random gap when in_idle is set, and wait until it is accepted.
  task automatic send_job(input job_req_t j);
    int gap;
    gap = in_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.job_id <= j.id;
    in_chan.burst_time <= j.burst;
    in_chan.priority_level <= j.prio;
    in_chan.func_code <= j.func;
    in_chan.operand_a <= j.opa;
    in_chan.operand_b <= j.opb;
    in_chan.last_job <= j.last;
    do @(posedge clk); while (!in_chan.ready);
    predict_job(j);
    jobs_sent++;
  endtask

  // Let every expected result come out, then allow for a scan in progress.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (RUN_GAP) @(posedge clk);
  endtask

  // Write the scheduling mode once the block is idle.
  task automatic set_mode(input logic [jos_pkg::MODE_W-1:0] mode);
    wait_drained();
    cfg_chan.valid <= 1'b1;
    cfg_chan.data <= mode;
    do @(posedge clk); while (!cfg_chan.ready);
    sched_mode = mode;
    modes_used[mode] = 1'b1;
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // First come first served from reset: field extremes, every function code,
  // an overwritten job number and a load order unlike the job order.
  task automatic test_fcfs_order();
    send_job(make_job(5'd16, 16'hffff, 8'hff, FUNC_FIB, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0));
    send_job(make_job(5'd1, 16'h0000, 8'h00, FUNC_SUM, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0));
    send_job(make_job(5'd8, 16'd100, 8'd7, FUNC_PRODUCT, -32'sd1, 32'sd0, 1'b0));
    send_job(make_job(5'd8, 16'd200, 8'd9, FUNC_POWER, 32'sd0, -32'sd1, 1'b0));
    send_job(make_job(5'd5, 16'h5a5a, 8'ha5, FUNC_SUM, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b1));
  endtask

  // Job numbers 0 and above the table store nothing, but their last bit
  // still starts a run; a last request on an empty table gives nothing.
  task automatic test_stray_ids();
    send_job(make_job(5'd0, 16'd1, 8'd1, FUNC_SUM, 32'sd1, 32'sd1, 1'b0));
    send_job(make_job(5'd31, 16'd2, 8'd2, FUNC_PRODUCT, 32'sd2, 32'sd2, 1'b0));
    send_job(make_job(5'd17, 16'd3, 8'd3, FUNC_POWER, 32'sd3, 32'sd3, 1'b0));
    send_job(make_job(5'd3, 16'd4, 8'd4, FUNC_FIB, 32'sd4, 32'sd4, 1'b0));
    send_job(make_job(5'd0, 16'd5, 8'd5, FUNC_SUM, 32'sd5, 32'sd5, 1'b1));
    send_job(make_job(5'd0, 16'd6, 8'd6, FUNC_SUM, 32'sd6, 32'sd6, 1'b1));
    send_job(make_job(5'd31, 16'd7, 8'd7, FUNC_SUM, 32'sd7, 32'sd7, 1'b1));
  endtask

  // Shortest job first with equal bursts that must stay in job order.
  task automatic test_shortest_first();
    set_mode(jos_pkg::MODE_SJF);
    send_job(make_job(5'd4, 16'd50, 8'd1, FUNC_SUM, 32'sd40, 32'sd41, 1'b0));
    send_job(make_job(5'd2, 16'd50, 8'd2, FUNC_PRODUCT, 32'sd20, 32'sd21, 1'b0));
    send_job(make_job(5'd9, 16'd10, 8'd3, FUNC_POWER, 32'sd90, 32'sd91, 1'b0));
    send_job(make_job(5'd12, 16'hffff, 8'd4, FUNC_FIB, 32'sd120, 32'sd121, 1'b0));
    send_job(make_job(5'd1, 16'd0, 8'd5, FUNC_SUM, 32'sd10, 32'sd11, 1'b0));
    send_job(make_job(5'd7, 16'd50, 8'd6, FUNC_SUM, 32'sd70, 32'sd71, 1'b1));
  endtask

  // Priority order with ties and both priority extremes.
  task automatic test_priority_order();
    set_mode(jos_pkg::MODE_PRIO);
    send_job(make_job(5'd3, 16'd9, 8'd200, FUNC_SUM, 32'sd3, 32'sd3, 1'b0));
    send_job(make_job(5'd14, 16'd1, 8'd255, FUNC_PRODUCT, 32'sd14, 32'sd14, 1'b0));
    send_job(make_job(5'd10, 16'd5, 8'd200, FUNC_POWER, 32'sd10, 32'sd10, 1'b0));
    send_job(make_job(5'd6, 16'd7, 8'd0, FUNC_FIB, 32'sd6, 32'sd6, 1'b1));
  endtask

  // The unused mode code orders like first come first served.
  task automatic test_unused_mode();
    set_mode(MODE_UNUSED);
    send_job(make_job(5'd9, 16'd1, 8'd1, FUNC_SUM, 32'sd9, 32'sd9, 1'b0));
    send_job(make_job(5'd2, 16'd900, 8'd250, FUNC_FIB, 32'sd2, 32'sd2, 1'b1));
  endtask

  // Random batches: mostly well-formed loads ending in a last request, with
  // stray job numbers, early last requests and occasional full tables.
  task automatic test_random_batches(input int item_goal);
    int       counted;
    int       body_len;
    int       b;
    int       s;
    int       t;
    bit       narrow;
    bit       full_set;
    int       perm [jos_pkg::MAX_JOBS];
    job_req_t j;
    counted = 0;
    while (counted < item_goal) begin
      if ($urandom_range(0, 3) == 0) set_mode(jos_pkg::MODE_W'($urandom_range(0, 3)));
      in_idle = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      narrow = $urandom_range(0, 1);
      full_set = ($urandom_range(0, 7) == 0);
      body_len = full_set ? jos_pkg::MAX_JOBS - 1 : $urandom_range(0, 7);
      // Shuffled job numbers for a full table.
      for (b = 0; b < jos_pkg::MAX_JOBS; b++) perm[b] = b + 1;
      for (b = jos_pkg::MAX_JOBS - 1; b > 0; b--) begin
        s = $urandom_range(0, b);
        t = perm[b];
        perm[b] = perm[s];
        perm[s] = t;
      end
      for (b = 0; b <= body_len; b++) begin
        j = random_job(narrow);
        if (full_set) begin
          j.id = jos_pkg::ID_W'(perm[b]);
          j.last = (b == body_len);
        end else begin
          j.last = (b == body_len) || ($urandom_range(0, 19) == 0);
          if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 3) == 0) begin
              j.id = '0;
            end else begin
              j.id = jos_pkg::ID_W'($urandom_range(jos_pkg::MAX_JOBS + 1, ID_MAX));
            end
          end
        end
        counted++;
        send_job(j);
      end
    end
  endtask

  // Result receiver: random stalls per result when out_idle is set, owned by this process alone.
  initial begin : result_sink
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin : result_check
    job_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result for job %0d", out_chan.out_job_id));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_chan.out_job_id !== want.job_id)
          report_mismatch($sformatf("job_id got %0d expected %0d",
                                    out_chan.out_job_id, want.job_id));
        if (out_chan.out_burst !== want.burst)
          report_mismatch($sformatf("job %0d burst got %0d expected %0d",
                                    want.job_id, out_chan.out_burst, want.burst));
        if (out_chan.out_priority !== want.prio)
          report_mismatch($sformatf("job %0d priority got %0d expected %0d",
                                    want.job_id, out_chan.out_priority, want.prio));
        if (out_chan.out_func !== want.func)
          report_mismatch($sformatf("job %0d func got %0d expected %0d",
                                    want.job_id, out_chan.out_func, want.func));
        if (out_chan.out_operand_a !== want.opa)
          report_mismatch($sformatf("job %0d operand_a got %0h expected %0h",
                                    want.job_id, out_chan.out_operand_a, want.opa));
        if (out_chan.out_operand_b !== want.opb)
          report_mismatch($sformatf("job %0d operand_b got %0h expected %0h",
                                    want.job_id, out_chan.out_operand_b, want.opb));
        if (out_chan.out_last !== want.last)
          report_mismatch($sformatf("job %0d last got %0b expected %0b",
                                    want.job_id, out_chan.out_last, want.last));
      end
    end
  end

  // Main sequence: reset, directed tests, random batches, then the verdict.
  initial begin : main_seq
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.job_id <= '0;
    in_chan.burst_time <= '0;
    in_chan.priority_level <= '0;
    in_chan.func_code <= '0;
    in_chan.operand_a <= '0;
    in_chan.operand_b <= '0;
    in_chan.last_job <= 1'b0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fcfs_order();
    test_stray_ids();
    test_shortest_first();
    test_priority_order();
    test_unused_mode();
    test_random_batches(356);
    wait_drained();

    $display("Covered %0d job requests and %0d ordered results over %0d runs.",
             jobs_sent, results_checked, runs_started);
    $display("Scheduling modes written: %b (bit per mode code), mismatches: %0d.",
             modes_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #20ms;
    $display("Timeout with %0d results still expected.", pending_results.size());
    $display("tb failed");
    $finish;
  end

endmodule
